/* hw/rtl/x86dec_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86dec_pkg
// shared types, operation and format codes for the 16-bit instruction decoder
// ----------------------------------------------------------------------------
package x86dec_pkg;

  localparam int unsigned InBytes   = 6;
  localparam int unsigned InWidth   = InBytes * 8;
  localparam int unsigned OutWidth  = 56;
  localparam int unsigned RegCount  = 8;

  // operation codes
  localparam logic [4:0] OP_MOV    = 5'd0;
  localparam logic [4:0] OP_ADD    = 5'd1;
  localparam logic [4:0] OP_SUB    = 5'd2;
  localparam logic [4:0] OP_CMP    = 5'd3;
  localparam logic [4:0] OP_JCC    = 5'd4;
  localparam logic [4:0] OP_LOOP   = 5'd20;
  localparam logic [4:0] OP_LOOPZ  = 5'd21;
  localparam logic [4:0] OP_LOOPNZ = 5'd22;
  localparam logic [4:0] OP_JCXZ   = 5'd23;

  // encoding formats
  localparam logic [2:0] FMT_IMM_REG = 3'd0;
  localparam logic [2:0] FMT_IMM_ACC = 3'd1;
  localparam logic [2:0] FMT_IMM_RM  = 3'd2;
  localparam logic [2:0] FMT_RM_RM   = 3'd3;
  localparam logic [2:0] FMT_JUMP    = 3'd4;

  // opcode patterns
  localparam logic [3:0] PAT_MOV_IMM_REG = 4'b1011;
  localparam logic [6:0] PAT_ADD_IMM_ACC = 7'b0000010;
  localparam logic [6:0] PAT_SUB_IMM_ACC = 7'b0010110;
  localparam logic [6:0] PAT_CMP_IMM_ACC = 7'b0011110;
  localparam logic [5:0] PAT_GRP_IMM_RM  = 6'b100000;
  localparam logic [5:0] PAT_MOV_RM      = 6'b100010;
  localparam logic [5:0] PAT_ADD_RM      = 6'b000000;
  localparam logic [5:0] PAT_SUB_RM      = 6'b001010;
  localparam logic [5:0] PAT_CMP_RM      = 6'b001110;
  localparam logic [3:0] PAT_JCC         = 4'b0111;
  localparam logic [5:0] PAT_LOOP        = 6'b111000;

  // group extension codes
  localparam logic [2:0] EXT_ADD = 3'b000;
  localparam logic [2:0] EXT_SUB = 3'b101;
  localparam logic [2:0] EXT_CMP = 3'b111;

  localparam logic [1:0] MOD_NONE  = 2'd0;
  localparam logic [1:0] MOD_DISP8 = 2'd1;
  localparam logic [1:0] MOD_DISP16 = 2'd2;
  localparam logic [2:0] RM_DIRECT = 3'b110;

  typedef struct packed {
    logic [15:0] immediate;
    logic [15:0] displacement;
    logic [2:0]  rm_field;
    logic [2:0]  reg_field;
    logic [1:0]  addr_mode;
    logic        to_reg;
    logic        wide;
    logic [2:0]  format;
    logic [4:0]  operation;
    logic [2:0]  length;
    logic        valid_res;
  } dec_res_t;

  typedef struct packed {
    logic        en;
    logic        wide;
    logic [2:0]  idx;
    logic [15:0] data;
  } rf_wr_t;

  function automatic logic [15:0] sext8(input logic [7:0] b);
    return {{8{b[7]}}, b};
  endfunction

endpackage

/* hw/rtl/x86dec_decode.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86dec_decode
// combinational decode of one six-byte instruction window
// ----------------------------------------------------------------------------
module x86dec_decode (
  input  logic [x86dec_pkg::InWidth-1:0] win_i,
  output x86dec_pkg::dec_res_t           res_o,
  output x86dec_pkg::rf_wr_t             rf_wr_o
);

  logic [7:0] b0, b1, b2, b3, b4, b5;

  assign b0 = win_i[7:0];
  assign b1 = win_i[15:8];
  assign b2 = win_i[23:16];
  assign b3 = win_i[31:24];
  assign b4 = win_i[39:32];
  assign b5 = win_i[47:40];

  always_comb begin
    x86dec_pkg::dec_res_t r;
    logic        ok;
    logic [1:0]  ndisp;
    logic [7:0]  ilo;
    logic [7:0]  ihi;
    logic [2:0]  pos;
    r  = '0;
    ok = 1'b1;
    ndisp = 2'd0;
    ilo = b2;
    ihi = b3;
    pos = 3'd2;
    rf_wr_o = '0;

    // displacement byte count from the modrm byte, shared by the modrm forms
    if (b1[7:6] == x86dec_pkg::MOD_DISP8) begin
      ndisp = 2'd1;
    end else if (b1[7:6] == x86dec_pkg::MOD_DISP16 ||
                 (b1[7:6] == x86dec_pkg::MOD_NONE && b1[2:0] == x86dec_pkg::RM_DIRECT)) begin
      ndisp = 2'd2;
    end

    if (b0[7:4] == x86dec_pkg::PAT_MOV_IMM_REG) begin
      r.format    = x86dec_pkg::FMT_IMM_REG;
      r.operation = x86dec_pkg::OP_MOV;
      r.to_reg    = 1'b1;
      r.wide      = b0[3];
      r.reg_field = b0[2:0];
      r.immediate = b0[3] ? {b2, b1} : {8'h00, b1};
      r.length    = b0[3] ? 3'd3 : 3'd2;
      rf_wr_o.en   = 1'b1;
      rf_wr_o.wide = b0[3];
      rf_wr_o.idx  = b0[2:0];
      rf_wr_o.data = r.immediate;
    end else if (b0[7:1] == x86dec_pkg::PAT_ADD_IMM_ACC ||
                 b0[7:1] == x86dec_pkg::PAT_SUB_IMM_ACC ||
                 b0[7:1] == x86dec_pkg::PAT_CMP_IMM_ACC) begin
      r.format    = x86dec_pkg::FMT_IMM_ACC;
      r.to_reg    = 1'b1;
      if (b0[7:1] == x86dec_pkg::PAT_ADD_IMM_ACC) begin
        r.operation = x86dec_pkg::OP_ADD;
      end else if (b0[7:1] == x86dec_pkg::PAT_SUB_IMM_ACC) begin
        r.operation = x86dec_pkg::OP_SUB;
      end else begin
        r.operation = x86dec_pkg::OP_CMP;
      end
      r.wide      = b0[0];
      r.immediate = b0[0] ? {b2, b1} : {8'h00, b1};
      r.length    = b0[0] ? 3'd3 : 3'd2;
    end else if (b0[7:2] == x86dec_pkg::PAT_GRP_IMM_RM) begin
      r.format    = x86dec_pkg::FMT_IMM_RM;
      r.wide      = b0[0];
      r.addr_mode = b1[7:6];
      r.reg_field = b1[5:3];
      r.rm_field  = b1[2:0];
      if (b1[5:3] == x86dec_pkg::EXT_ADD) begin
        r.operation = x86dec_pkg::OP_ADD;
      end else if (b1[5:3] == x86dec_pkg::EXT_SUB) begin
        r.operation = x86dec_pkg::OP_SUB;
      end else if (b1[5:3] == x86dec_pkg::EXT_CMP) begin
        r.operation = x86dec_pkg::OP_CMP;
      end else begin
        ok = 1'b0;
      end
      case (ndisp)
        2'd1: begin
          r.displacement = x86dec_pkg::sext8(b2);
          ilo = b3;
          ihi = b4;
        end
        2'd2: begin
          r.displacement = {b3, b2};
          ilo = b4;
          ihi = b5;
        end
        default: begin
          ilo = b2;
          ihi = b3;
        end
      endcase
      pos = 3'd2 + {1'b0, ndisp};
      if (b0[0] && !b0[1]) begin
        r.immediate = {ihi, ilo};
        r.length    = pos + 3'd2;
      end else begin
        r.immediate = b0[0] ? x86dec_pkg::sext8(ilo) : {8'h00, ilo};
        r.length    = pos + 3'd1;
      end
    end else if (b0[7:2] == x86dec_pkg::PAT_MOV_RM || b0[7:2] == x86dec_pkg::PAT_ADD_RM ||
                 b0[7:2] == x86dec_pkg::PAT_SUB_RM || b0[7:2] == x86dec_pkg::PAT_CMP_RM) begin
      r.format = x86dec_pkg::FMT_RM_RM;
      if (b0[7:2] == x86dec_pkg::PAT_MOV_RM) begin
        r.operation = x86dec_pkg::OP_MOV;
      end else if (b0[7:2] == x86dec_pkg::PAT_ADD_RM) begin
        r.operation = x86dec_pkg::OP_ADD;
      end else if (b0[7:2] == x86dec_pkg::PAT_SUB_RM) begin
        r.operation = x86dec_pkg::OP_SUB;
      end else begin
        r.operation = x86dec_pkg::OP_CMP;
      end
      r.to_reg    = b0[1];
      r.wide      = b0[0];
      r.addr_mode = b1[7:6];
      r.reg_field = b1[5:3];
      r.rm_field  = b1[2:0];
      case (ndisp)
        2'd1:    r.displacement = x86dec_pkg::sext8(b2);
        2'd2:    r.displacement = {b3, b2};
        default: r.displacement = 16'h0000;
      endcase
      r.length = 3'd2 + {1'b0, ndisp};
    end else if (b0[7:4] == x86dec_pkg::PAT_JCC) begin
      r.format       = x86dec_pkg::FMT_JUMP;
      r.operation    = x86dec_pkg::OP_JCC + {1'b0, b0[3:0]};
      r.displacement = x86dec_pkg::sext8(b1);
      r.length       = 3'd2;
    end else if (b0[7:2] == x86dec_pkg::PAT_LOOP) begin
      r.format = x86dec_pkg::FMT_JUMP;
      case (b0[1:0])
        2'd0:    r.operation = x86dec_pkg::OP_LOOPNZ;
        2'd1:    r.operation = x86dec_pkg::OP_LOOPZ;
        2'd2:    r.operation = x86dec_pkg::OP_LOOP;
        default: r.operation = x86dec_pkg::OP_JCXZ;
      endcase
      r.displacement = x86dec_pkg::sext8(b1);
      r.length       = 3'd2;
    end else begin
      ok = 1'b0;
    end

    if (ok) begin
      r.valid_res = 1'b1;
      res_o = r;
    end else begin
      res_o = '0;
    end
  end

endmodule

/* hw/rtl/x86dec_regfile.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86dec_regfile
// eight 16-bit registers written by mov immediate, byte or word halves
// ----------------------------------------------------------------------------
module x86dec_regfile (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  x86dec_pkg::rf_wr_t wr_i,
  output logic [15:0]        acc_o
);

  logic [7:0] lo_q [x86dec_pkg::RegCount];
  logic [7:0] hi_q [x86dec_pkg::RegCount];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < x86dec_pkg::RegCount; i++) begin
        lo_q[i] <= 8'h00;
        hi_q[i] <= 8'h00;
      end
    end else if (wr_i.en) begin
      if (wr_i.wide) begin
        lo_q[wr_i.idx] <= wr_i.data[7:0];
        hi_q[wr_i.idx] <= wr_i.data[15:8];
      end else if (!wr_i.idx[2]) begin
        lo_q[{1'b0, wr_i.idx[1:0]}] <= wr_i.data[7:0];
      end else begin
        // ah ch dh bh map onto the high half of registers 0..3
        hi_q[{1'b0, wr_i.idx[1:0]}] <= wr_i.data[7:0];
      end
    end
  end

  assign acc_o = {hi_q[0], lo_q[0]};

endmodule

/* hw/rtl/x86_16bit_instruction_decoder.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86_16bit_instruction_decoder
// an input transfer passes the input register, then the result register, to the master side
// throughput one instruction per cycle while the master side does not stall
// decode is a single pass of combinational logic between the two registers
// reset clears both valid flags and the register file to zero
// ----------------------------------------------------------------------------
module x86_16bit_instruction_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // byte0, byte1, byte2, byte3, byte4, byte5
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // valid_res, length, operation, format, wide, to_reg, addr_mode, reg_field,
  // rm_field, displacement, immediate, zero pad
  output logic [55:0] m_axis_tdata
);

  logic                                  in_v_q;
  logic [x86dec_pkg::InWidth-1:0]        in_data_q;
  logic                                  out_v_q;
  logic [x86dec_pkg::OutWidth-1:0]       out_data_q;
  logic [x86dec_pkg::OutWidth-1:0]       out_data_d;
  logic                                  adv;
  x86dec_pkg::dec_res_t                  res;
  x86dec_pkg::rf_wr_t                    rf_wr;
  x86dec_pkg::rf_wr_t                    rf_wr_gated;
  logic [15:0]                           acc;

  assign adv           = in_v_q && (!out_v_q || m_axis_tready);
  assign s_axis_tready = !in_v_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_v_q <= s_axis_tvalid;
      end
      if (!out_v_q || m_axis_tready) begin
        out_v_q <= in_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_data_q <= s_axis_tdata;
    end
    if (adv) begin
      out_data_q <= out_data_d;
    end
  end

  x86dec_decode u_decode (
    .win_i   (in_data_q),
    .res_o   (res),
    .rf_wr_o (rf_wr)
  );

  always_comb begin
    rf_wr_gated    = rf_wr;
    rf_wr_gated.en = rf_wr.en && adv;
  end

  x86dec_regfile u_regfile (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (rf_wr_gated),
    .acc_o  (acc)
  );

  // accumulator readback is not part of the result
  assign out_data_d = {2'b00, res} | {x86dec_pkg::OutWidth{1'b0 & acc[0]}};

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* hw/rtl/x86dec_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// x86dec_checker
// port-level checks on the decoder result stream
// ----------------------------------------------------------------------------
module x86dec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [55:0] m_axis_tdata
);

  // stalled transfer holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // undecodable opcode gives an all-zero result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[55:1] == 55'd0)
    else $error("invalid result carries non-zero fields");

  // decoded length lies between two and six bytes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] |->
      m_axis_tdata[3:1] >= 3'd2 && m_axis_tdata[3:1] <= 3'd6)
    else $error("decoded length out of range");

  // short jumps are always two bytes with no immediate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[0] && m_axis_tdata[11:9] == 3'd4 |->
      m_axis_tdata[3:1] == 3'd2 && m_axis_tdata[53:38] == 16'd0)
    else $error("short jump with bad length or immediate");

endmodule

bind x86_16bit_instruction_decoder x86dec_checker u_x86dec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* test/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// stream-level test of the 16-bit instruction decoder: a table of directed
// windows, then random windows mostly built from supported opcode classes,
// each checked against a local model or its table row, field by field on the
// master side, with random idle bursts on both sides of the decoder
// ----------------------------------------------------------------------------
module tb_top;
  import x86dec_pkg::*;

  typedef logic [5:0][7:0] window_t;

  typedef struct {
    window_t  win;
    bit       typed;
    dec_res_t res;
  } stim_row_t;

  localparam int unsigned RandItems = 550;
  localparam int unsigned CalmFrom  = 450;
  localparam int unsigned CycleLimit = 200000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_tdata;
  logic        m_axis_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_axis_tdata;

  logic        cur_typed;
  dec_res_t    cur_res;
  logic        idle_en;
  int unsigned stall_left = 0;
  int unsigned cycles = 0;
  int unsigned errors = 0;

  logic [15:0] gpr [0:RegCount-1];
  dec_res_t    decoded_q [$];
  stim_row_t   dir_rows [$];

  x86_16bit_instruction_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic int unsigned disp_bytes(input window_t w, input logic [1:0] md,
                                             input logic [2:0] rm,
                                             output logic [15:0] disp);
    if (md == MOD_DISP8) begin
      disp = {{8{w[2][7]}}, w[2]};
      return 1;
    end
    if (md == MOD_DISP16 || (md == MOD_NONE && rm == RM_DIRECT)) begin
      disp = {w[3], w[2]};
      return 2;
    end
    disp = 16'h0000;
    return 0;
  endfunction

  // decodes one window and applies a mov immediate to the register copy
  function automatic dec_res_t decode_insn(input window_t w);
    dec_res_t    r;
    logic        ok;
    logic        sbit;
    int unsigned n;
    int unsigned p;
    logic [15:0] d;
    r  = '0;
    ok = 1'b1;
    if (w[0][7:4] == PAT_MOV_IMM_REG) begin
      r.format    = FMT_IMM_REG;
      r.operation = OP_MOV;
      r.to_reg    = 1'b1;
      r.wide      = w[0][3];
      r.reg_field = w[0][2:0];
      if (r.wide) begin
        r.immediate = {w[2], w[1]};
        r.length    = 3'd3;
        gpr[r.reg_field] = r.immediate;
      end else begin
        r.immediate = {8'h00, w[1]};
        r.length    = 3'd2;
        if (r.reg_field < 3'd4) gpr[r.reg_field][7:0] = w[1];
        else gpr[r.reg_field - 3'd4][15:8] = w[1];
      end
    end else if (w[0][7:1] == PAT_ADD_IMM_ACC || w[0][7:1] == PAT_SUB_IMM_ACC ||
                 w[0][7:1] == PAT_CMP_IMM_ACC) begin
      r.format    = FMT_IMM_ACC;
      r.to_reg    = 1'b1;
      r.operation = (w[0][7:1] == PAT_ADD_IMM_ACC) ? OP_ADD :
                    (w[0][7:1] == PAT_SUB_IMM_ACC) ? OP_SUB : OP_CMP;
      r.wide      = w[0][0];
      if (r.wide) begin
        r.immediate = {w[2], w[1]};
        r.length    = 3'd3;
      end else begin
        r.immediate = {8'h00, w[1]};
        r.length    = 3'd2;
      end
    end else if (w[0][7:2] == PAT_GRP_IMM_RM) begin
      sbit        = w[0][1];
      r.format    = FMT_IMM_RM;
      r.wide      = w[0][0];
      r.addr_mode = w[1][7:6];
      r.reg_field = w[1][5:3];
      r.rm_field  = w[1][2:0];
      case (r.reg_field)
        EXT_ADD: r.operation = OP_ADD;
        EXT_SUB: r.operation = OP_SUB;
        EXT_CMP: r.operation = OP_CMP;
        default: ok = 1'b0;
      endcase
      n = disp_bytes(w, r.addr_mode, r.rm_field, d);
      r.displacement = d;
      p = 2 + n;
      if (r.wide && !sbit) begin
        r.immediate = {w[p+1], w[p]};
        r.length    = 3'(p + 2);
      end else begin
        r.immediate = (r.wide && sbit) ? {{8{w[p][7]}}, w[p]} : {8'h00, w[p]};
        r.length    = 3'(p + 1);
      end
    end else if (w[0][7:2] == PAT_MOV_RM || w[0][7:2] == PAT_ADD_RM ||
                 w[0][7:2] == PAT_SUB_RM || w[0][7:2] == PAT_CMP_RM) begin
      r.format    = FMT_RM_RM;
      r.operation = (w[0][7:2] == PAT_MOV_RM) ? OP_MOV :
                    (w[0][7:2] == PAT_ADD_RM) ? OP_ADD :
                    (w[0][7:2] == PAT_SUB_RM) ? OP_SUB : OP_CMP;
      r.to_reg    = w[0][1];
      r.wide      = w[0][0];
      r.addr_mode = w[1][7:6];
      r.reg_field = w[1][5:3];
      r.rm_field  = w[1][2:0];
      n = disp_bytes(w, r.addr_mode, r.rm_field, d);
      r.displacement = d;
      r.length       = 3'(2 + n);
    end else if (w[0][7:4] == PAT_JCC) begin
      r.format       = FMT_JUMP;
      r.operation    = OP_JCC + {1'b0, w[0][3:0]};
      r.displacement = {{8{w[1][7]}}, w[1]};
      r.length       = 3'd2;
    end else if (w[0][7:2] == PAT_LOOP) begin
      r.format = FMT_JUMP;
      case (w[0][1:0])
        2'd0:    r.operation = OP_LOOPNZ;
        2'd1:    r.operation = OP_LOOPZ;
        2'd2:    r.operation = OP_LOOP;
        default: r.operation = OP_JCXZ;
      endcase
      r.displacement = {{8{w[1][7]}}, w[1]};
      r.length       = 3'd2;
    end else begin
      ok = 1'b0;
    end
    if (!ok) r = '0;
    else r.valid_res = 1'b1;
    return r;
  endfunction

  function automatic string res_str(input dec_res_t r);
    return $sformatf("v=%0d len=%0d op=%0d fmt=%0d w=%0d d=%0d mod=%0d reg=%0d rm=%0d disp=%h imm=%h",
                     r.valid_res, r.length, r.operation, r.format, r.wide, r.to_reg,
                     r.addr_mode, r.reg_field, r.rm_field, r.displacement, r.immediate);
  endfunction

  function automatic window_t win6(input logic [7:0] b0, input logic [7:0] b1,
                                   input logic [7:0] b2, input logic [7:0] b3,
                                   input logic [7:0] b4, input logic [7:0] b5);
    return {b5, b4, b3, b2, b1, b0};
  endfunction

  function automatic void add_row(input window_t w, input bit typed, input dec_res_t r);
    stim_row_t row;
    row.win   = w;
    row.typed = typed;
    row.res   = r;
    dir_rows.push_back(row);
  endfunction

  // mostly supported opcode classes with random operand bytes, some noise
  function automatic window_t rand_window();
    window_t     w;
    int unsigned k;
    logic [2:0]  ext;
    w = 48'({$urandom(), $urandom()});
    k = $urandom_range(0, 99);
    if (k < 15) begin
      w[0][7:4] = PAT_MOV_IMM_REG;
    end else if (k < 27) begin
      case ($urandom_range(0, 2))
        0:       w[0][7:1] = PAT_ADD_IMM_ACC;
        1:       w[0][7:1] = PAT_SUB_IMM_ACC;
        default: w[0][7:1] = PAT_CMP_IMM_ACC;
      endcase
    end else if (k < 47) begin
      w[0][7:2] = PAT_GRP_IMM_RM;
      if ($urandom_range(0, 99) < 85) begin
        case ($urandom_range(0, 2))
          0:       ext = EXT_ADD;
          1:       ext = EXT_SUB;
          default: ext = EXT_CMP;
        endcase
        w[1][5:3] = ext;
      end
    end else if (k < 72) begin
      case ($urandom_range(0, 3))
        0:       w[0][7:2] = PAT_MOV_RM;
        1:       w[0][7:2] = PAT_ADD_RM;
        2:       w[0][7:2] = PAT_SUB_RM;
        default: w[0][7:2] = PAT_CMP_RM;
      endcase
    end else if (k < 82) begin
      w[0][7:4] = PAT_JCC;
    end else if (k < 88) begin
      w[0][7:2] = PAT_LOOP;
    end
    return w;
  endfunction

  task automatic push_insn(input window_t w, input bit typed, input dec_res_t r);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_tvalid  <= 1'b1;
    s_tdata   <= w;
    cur_typed <= typed;
    cur_res   <= r;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  // sink side stall bursts
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready   <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 13) - 1;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    dec_res_t got;
    dec_res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_tready) begin
        got = dec_res_t'(m_axis_tdata[$bits(dec_res_t)-1:0]);
        if (decoded_q.size() == 0) begin
          if (errors < 10) $display("unexpected result transfer: %s", res_str(got));
          errors++;
        end else begin
          want = decoded_q.pop_front();
          if (got.valid_res !== want.valid_res || got.length !== want.length ||
              got.operation !== want.operation || got.format !== want.format ||
              got.wide !== want.wide || got.to_reg !== want.to_reg ||
              got.addr_mode !== want.addr_mode || got.reg_field !== want.reg_field ||
              got.rm_field !== want.rm_field || got.displacement !== want.displacement ||
              got.immediate !== want.immediate) begin
            if (errors < 10) begin
              $display("mismatch exp: %s", res_str(want));
              $display("         act: %s", res_str(got));
            end
            errors++;
          end
        end
      end
      if (s_tvalid && s_axis_tready) begin
        want = decode_insn(s_tdata);
        decoded_q.push_back(cur_typed ? cur_res : want);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    dec_res_t z;
    dec_res_t jo;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cur_typed = 1'b0;
    cur_res   = '0;
    idle_en   = 1'b1;
    for (int i = 0; i < RegCount; i++) gpr[i] = 16'h0000;

    z  = '0;
    jo = '0;
    jo.valid_res    = 1'b1;
    jo.length       = 3'd2;
    jo.operation    = OP_JCC;
    jo.format       = FMT_JUMP;
    jo.displacement = 16'hff80;

    add_row(win6(8'hb8, 8'h34, 8'h12, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'hb0, 8'hff, 8'haa, 8'h55, 8'haa, 8'h55), 0, z);
    add_row(win6(8'hb4, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'hbf, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 0, z);
    add_row(win6(8'h04, 8'h7f, 8'hff, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h05, 8'hff, 8'hff, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h3d, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00), 0, z);
    // direct address, byte immediate
    add_row(win6(8'h80, 8'h06, 8'h34, 8'h12, 8'hff, 8'h00), 0, z);
    add_row(win6(8'h81, 8'hc0, 8'hff, 8'hff, 8'h00, 8'h00), 0, z);
    // s bit with word operand: sign extended
    add_row(win6(8'h83, 8'he8, 8'h80, 8'h00, 8'h00, 8'h00), 0, z);
    // s bit with byte operand: zero extended
    add_row(win6(8'h82, 8'hf8, 8'h80, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h81, 8'h46, 8'h80, 8'h34, 8'h12, 8'h00), 0, z);
    add_row(win6(8'h81, 8'h86, 8'h00, 8'h80, 8'hff, 8'hff), 0, z);
    // unsupported group extensions
    add_row(win6(8'h80, 8'h08, 8'h12, 8'h34, 8'h56, 8'h78), 1, z);
    add_row(win6(8'h83, 8'he0, 8'h01, 8'h00, 8'h00, 8'h00), 1, z);
    add_row(win6(8'h89, 8'hd8, 8'h12, 8'h34, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h8b, 8'h06, 8'hfe, 8'hff, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h01, 8'h47, 8'h80, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h2b, 8'h87, 8'h01, 8'h80, 8'h00, 8'h00), 0, z);
    add_row(win6(8'h70, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00), 1, jo);
    add_row(win6(8'he0, 8'hfe, 8'h00, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'he1, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'he2, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00), 0, z);
    add_row(win6(8'he3, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00), 0, z);
    // unknown opcode
    add_row(win6(8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff), 1, z);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) push_insn(dir_rows[i].win, dir_rows[i].typed, dir_rows[i].res);
    for (int unsigned i = 0; i < RandItems; i++) begin
      if (i == CalmFrom) idle_en <= 1'b0;
      push_insn(rand_window(), 0, z);
    end
    s_tvalid <= 1'b0;

    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (errors == 0 && decoded_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
